[hw/rtl/cll_pkg.sv]
// cll_pkg: shared types, constants and character-class functions of the lexer.
// Used by every module of c_like_lexer; no dependencies of its own.
`timescale 1ns / 1ps
package cll_pkg;

  localparam int LINE_COLUMNS   = 4096;
  localparam int COL_W          = $clog2(LINE_COLUMNS);
  localparam int LEN_W          = COL_W + 1;
  localparam int WORD_MATCH_LEN = 8;
  localparam int WB_IW          = $clog2(WORD_MATCH_LEN);
  localparam int WORD_W         = 8 * WORD_MATCH_LEN;
  localparam int MAX_RES        = 4;
  localparam int CNT_W          = $clog2(MAX_RES + 1);
  localparam int RIDX_W         = $clog2(MAX_RES);
  localparam int QDEPTH         = 2;
  localparam int QPTR_W         = $clog2(QDEPTH);
  localparam int QCNT_W         = $clog2(QDEPTH + 1);
  localparam int NWORDS         = 19;

  localparam logic [5:0] KIND_NUM  = 6'd0;
  localparam logic [5:0] KIND_CHAR = 6'd1;
  localparam logic [5:0] KIND_STR  = 6'd2;
  localparam logic [5:0] KIND_ID   = 6'd48;
  localparam logic [5:0] KIND_END  = 6'd61;

  localparam logic [3:0] M_IDLE  = 4'd0;
  localparam logic [3:0] M_INT   = 4'd1;
  localparam logic [3:0] M_FRAC  = 4'd2;
  localparam logic [3:0] M_IDENT = 4'd3;
  localparam logic [3:0] M_STR   = 4'd4;
  localparam logic [3:0] M_Q1    = 4'd5;
  localparam logic [3:0] M_Q2    = 4'd6;
  localparam logic [3:0] M_OP    = 4'd7;

  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_DQ = 8'h22;
  localparam logic [7:0] CH_SQ = 8'h27;

  localparam logic [WORD_W-1:0] WTXT [NWORDS] = '{
    WORD_W'("int"), WORD_W'("float"), WORD_W'("double"), WORD_W'("char"),
    WORD_W'("bool"), WORD_W'("size_t"), WORD_W'("void"), WORD_W'("if"),
    WORD_W'("else"), WORD_W'("for"), WORD_W'("while"), WORD_W'("struct"),
    WORD_W'("break"), WORD_W'("continue"), WORD_W'("const"), WORD_W'("do"),
    WORD_W'("false"), WORD_W'("true"), WORD_W'("return")};
  localparam logic [LEN_W-1:0] WLEN [NWORDS] = '{
    LEN_W'(3), LEN_W'(5), LEN_W'(6), LEN_W'(4), LEN_W'(4), LEN_W'(6), LEN_W'(4),
    LEN_W'(2), LEN_W'(4), LEN_W'(3), LEN_W'(5), LEN_W'(6), LEN_W'(5), LEN_W'(8),
    LEN_W'(5), LEN_W'(2), LEN_W'(5), LEN_W'(4), LEN_W'(6)};
  localparam logic [5:0] WKIND [NWORDS] = '{
    6'd3, 6'd3, 6'd3, 6'd3, 6'd3, 6'd3, 6'd3, 6'd49, 6'd50, 6'd51, 6'd52, 6'd53,
    6'd54, 6'd55, 6'd56, 6'd57, 6'd58, 6'd59, 6'd60};

  typedef struct packed {
    logic [7:0] byte_req;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [5:0]       token_kind;
    logic [COL_W-1:0] token_column;
    logic [LEN_W-1:0] token_length;
    logic             last_of_run;
  } out_t;

  typedef struct packed {
    logic [5:0]       kind;
    logic [COL_W-1:0] col;
    logic [LEN_W-1:0] len;
  } tok_t;

  // all tokens caused by one input beat
  typedef struct packed {
    logic [CNT_W-1:0]           cnt;
    tok_t [MAX_RES-1:0]         tok;
  } grp_t;

  typedef struct packed {
    logic valid;
    grp_t grp;
  } qrd_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] kind;
  } op_t;

  typedef struct packed {
    logic [3:0]                     mode;
    logic [COL_W-1:0]               sc;
    logic [LEN_W-1:0]               wl;
    logic [7:0]                     h0;
    logic [7:0]                     h1;
    logic [WORD_MATCH_LEN-1:0][7:0] wb;
  } st_t;

  typedef struct packed {
    logic [3:0] mode;
    logic       ev;
    logic [5:0] ek;
  } start_t;

  typedef struct packed {
    logic ev;
    tok_t tok;
  } emit_t;

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic holds(logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" || c == "^" ||
           c == "&" || c == "|" || c == "=" || c == "!" || c == ">" || c == "<";
  endfunction

  function automatic op_t one_op(logic [7:0] c);
    op_t r;
    r.ok = 1'b1;
    unique case (c)
      "+": r.kind = 6'd4;   "-": r.kind = 6'd5;   "*": r.kind = 6'd6;
      "/": r.kind = 6'd7;   "%": r.kind = 6'd8;   "=": r.kind = 6'd10;
      ">": r.kind = 6'd21;  "<": r.kind = 6'd22;  "!": r.kind = 6'd25;
      "?": r.kind = 6'd28;  "&": r.kind = 6'd29;  "|": r.kind = 6'd30;
      "^": r.kind = 6'd31;  "~": r.kind = 6'd32;  ".": r.kind = 6'd39;
      default: begin
        r.ok = 1'b0;
        r.kind = KIND_END;
      end
    endcase
    return r;
  endfunction

  function automatic op_t punct(logic [7:0] c);
    op_t r;
    r.ok = 1'b1;
    unique case (c)
      ",": r.kind = 6'd41;  ":": r.kind = 6'd42;  ";": r.kind = 6'd43;
      "(": r.kind = 6'd44;  ")": r.kind = 6'd45;  "{": r.kind = 6'd46;
      "}": r.kind = 6'd47;  "[": r.kind = 6'd37;  "]": r.kind = 6'd38;
      default: begin
        r.ok = 1'b0;
        r.kind = KIND_END;
      end
    endcase
    return r;
  endfunction

  function automatic op_t two_op(logic [7:0] a, logic [7:0] b);
    op_t r;
    r.ok = 1'b0;
    r.kind = KIND_END;
    if (b == "=") begin
      r.ok = 1'b1;
      unique case (a)
        "+": r.kind = 6'd11;  "-": r.kind = 6'd12;  "*": r.kind = 6'd13;
        "/": r.kind = 6'd14;  "%": r.kind = 6'd15;  "&": r.kind = 6'd16;
        "^": r.kind = 6'd17;  "|": r.kind = 6'd18;  "=": r.kind = 6'd19;
        "!": r.kind = 6'd20;  ">": r.kind = 6'd23;  "<": r.kind = 6'd24;
        default: r.ok = 1'b0;
      endcase
    end else if (a == b) begin
      r.ok = 1'b1;
      unique case (a)
        "^": r.kind = 6'd9;   "&": r.kind = 6'd26;  "|": r.kind = 6'd27;
        "<": r.kind = 6'd33;  ">": r.kind = 6'd34;  "+": r.kind = 6'd35;
        "-": r.kind = 6'd36;
        default: r.ok = 1'b0;
      endcase
    end else if (a == "-" && b == ">") begin
      r.ok = 1'b1;
      r.kind = 6'd40;
    end
    return r;
  endfunction

  function automatic logic [COL_W-1:0] next_col(logic [COL_W-1:0] c);
    return (c == COL_W'(LINE_COLUMNS - 1)) ? c : c + 1'b1;
  endfunction

  function automatic logic [LEN_W-1:0] grow(logic [LEN_W-1:0] l);
    return (l < LEN_W'(LINE_COLUMNS)) ? l + 1'b1 : l;
  endfunction

  function automatic tok_t mk(logic [5:0] k, logic [COL_W-1:0] c, logic [LEN_W-1:0] l);
    tok_t t;
    t.kind = k;
    t.col  = c;
    t.len  = l;
    return t;
  endfunction

  function automatic grp_t grp_add(grp_t g, tok_t t);
    grp_t r;
    r = g;
    r.tok[g.cnt[RIDX_W-1:0]] = t;
    r.cnt = g.cnt + 1'b1;
    return r;
  endfunction

  // word buffer packed right-aligned, first character most significant
  function automatic logic [5:0] classify(logic [WORD_MATCH_LEN-1:0][7:0] wb,
                                          logic [LEN_W-1:0] wl);
    logic [WORD_W-1:0] w;
    logic [5:0]        k;
    w = '0;
    k = KIND_ID;
    for (int i = 0; i < WORD_MATCH_LEN; i++)
      if (LEN_W'(i) < wl) w = {w[WORD_W-9:0], wb[i]};
    if (wl <= LEN_W'(WORD_MATCH_LEN))
      for (int j = 0; j < NWORDS; j++)
        if (WLEN[j] == wl && WTXT[j] == w) k = WKIND[j];
    return k;
  endfunction

  function automatic start_t start_f(logic [7:0] c);
    start_t r;
    op_t    o;
    op_t    p;
    o = one_op(c);
    p = punct(c);
    r.mode = M_IDLE;
    r.ev = 1'b0;
    r.ek = KIND_END;
    if (is_digit(c))      r.mode = M_INT;
    else if (c == CH_DQ)  r.mode = M_STR;
    else if (c == CH_SQ)  r.mode = M_Q1;
    else if (is_alpha(c)) r.mode = M_IDENT;
    else if (holds(c))    r.mode = M_OP;
    else if (o.ok) begin
      r.ev = 1'b1;
      r.ek = o.kind;
    end else if (p.ok) begin
      r.ev = 1'b1;
      r.ek = p.kind;
    end else if (c >= 8'd33 && c <= 8'd126) begin
      r.ev = 1'b1;
    end
    return r;
  endfunction

  function automatic st_t apply_start(st_t s, logic [7:0] c, logic [COL_W-1:0] at);
    st_t    r;
    start_t sf;
    r = s;
    sf = start_f(c);
    r.mode = sf.mode;
    r.sc = at;
    r.wl = LEN_W'(1);
    if (is_alpha(c)) r.wb[0] = c;
    if (holds(c)) r.h0 = c;
    return r;
  endfunction

  // pending token of any mode but the second quote state
  function automatic emit_t flush_simple(st_t s);
    emit_t e;
    e.ev = 1'b1;
    e.tok = mk(KIND_NUM, s.sc, s.wl);
    unique case (s.mode)
      M_INT, M_FRAC: e.tok = mk(KIND_NUM, s.sc, s.wl);
      M_IDENT:       e.tok = mk(classify(s.wb, s.wl), s.sc, s.wl);
      M_STR:         e.tok = mk(KIND_STR, s.sc, s.wl);
      M_OP:          e.tok = mk(one_op(s.h0).kind, s.sc, LEN_W'(1));
      M_Q1:          e.tok = mk(KIND_END, s.sc, LEN_W'(1));
      default:       e.ev = 1'b0;
    endcase
    return e;
  endfunction

endpackage

[hw/rtl/cll_front.sv]
// cll_front: scanner state and per-beat token classification.
// Depends on cll_pkg; pushes at most one token group per beat into cll_queue.
`timescale 1ns / 1ps
module cll_front import cll_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic acc,
  input  in_t  in_data,
  output logic push,
  output grp_t push_grp
);

  st_t              st_r, st_nxt;
  logic [COL_W-1:0] col_r, col_nxt;

  always_comb begin
    st_t              s;
    logic [COL_W-1:0] colv;
    logic [COL_W-1:0] at;
    logic [7:0]       c;
    grp_t             g;
    start_t           sf;
    emit_t            fl;
    op_t              k;
    logic             do_start;
    s = st_r;
    colv = col_r;
    c = in_data.byte_req;
    g = '0;
    at = '0;
    sf = '0;
    fl = '0;
    k = '0;
    do_start = 1'b0;
    if (in_data.end_of_input || c == CH_NL) begin
      // quote then char: error for the quote, rescan the held char
      if (s.mode == M_Q2) begin
        g = grp_add(g, mk(KIND_END, s.sc, LEN_W'(1)));
        colv = next_col(s.sc);
        sf = start_f(s.h1);
        if (sf.ev) g = grp_add(g, mk(sf.ek, colv, LEN_W'(1)));
        s = apply_start(s, s.h1, colv);
      end
      fl = flush_simple(s);
      if (fl.ev) g = grp_add(g, fl.tok);
      s.mode = M_IDLE;
      if (in_data.end_of_input) begin
        g = grp_add(g, mk(KIND_END, colv, '0));
        s.sc = '0;
        s.wl = '0;
      end
      colv = '0;
    end else begin
      if (s.mode == M_Q2 && c != CH_SQ) begin
        g = grp_add(g, mk(KIND_END, s.sc, LEN_W'(1)));
        at = next_col(s.sc);
        sf = start_f(s.h1);
        if (sf.ev) g = grp_add(g, mk(sf.ek, at, LEN_W'(1)));
        s = apply_start(s, s.h1, at);
      end
      unique case (s.mode)
        M_INT: begin
          if (is_digit(c)) s.wl = grow(s.wl);
          else if (c == ".") begin
            s.wl = grow(s.wl);
            s.mode = M_FRAC;
          end else begin
            g = grp_add(g, mk(KIND_NUM, s.sc, s.wl));
            do_start = 1'b1;
          end
        end
        M_FRAC: begin
          if (is_digit(c)) s.wl = grow(s.wl);
          else begin
            g = grp_add(g, mk(KIND_NUM, s.sc, s.wl));
            do_start = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (s.wl < LEN_W'(WORD_MATCH_LEN)) s.wb[s.wl[WB_IW-1:0]] = c;
            s.wl = grow(s.wl);
          end else begin
            g = grp_add(g, mk(classify(s.wb, s.wl), s.sc, s.wl));
            do_start = 1'b1;
          end
        end
        M_STR: begin
          s.wl = grow(s.wl);
          if (c == CH_DQ) begin
            g = grp_add(g, mk(KIND_STR, s.sc, s.wl));
            s.mode = M_IDLE;
          end
        end
        M_Q1: begin
          s.h1 = c;
          s.wl = grow(s.wl);
          s.mode = M_Q2;
        end
        M_Q2: begin
          s.wl = grow(s.wl);
          g = grp_add(g, mk(KIND_CHAR, s.sc, s.wl));
          s.mode = M_IDLE;
        end
        M_OP: begin
          k = two_op(s.h0, c);
          if (k.ok) begin
            g = grp_add(g, mk(k.kind, s.sc, LEN_W'(2)));
            s.mode = M_IDLE;
          end else begin
            g = grp_add(g, mk(one_op(s.h0).kind, s.sc, LEN_W'(1)));
            do_start = 1'b1;
          end
        end
        default: do_start = 1'b1;
      endcase
      if (do_start) begin
        sf = start_f(c);
        if (sf.ev) g = grp_add(g, mk(sf.ek, colv, LEN_W'(1)));
        s = apply_start(s, c, colv);
      end
      colv = next_col(colv);
    end
    st_nxt = s;
    col_nxt = colv;
    push_grp = g;
    push = acc && (g.cnt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
      col_r <= '0;
    end else if (acc) begin
      st_r <= st_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

[hw/rtl/cll_queue.sv]
// cll_queue: two-entry queue of token groups between scanner and output side.
// Depends on cll_pkg.
`timescale 1ns / 1ps
module cll_queue import cll_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  grp_t push_grp,
  input  logic pop,
  output logic full,
  output qrd_t head
);

  grp_t              ent_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full = (cnt_r == QCNT_W'(QDEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.grp = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_grp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

[hw/rtl/cll_back.sv]
// cll_back: walks the head token group, one token per output beat.
// Depends on cll_pkg; reads the head of cll_queue.
`timescale 1ns / 1ps
module cll_back import cll_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  qrd_t head,
  output logic pop,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic [RIDX_W-1:0] idx_r;
  logic              last;
  tok_t              t;

  assign t = head.grp.tok[idx_r];
  assign last = ({1'b0, idx_r} + 1'b1) == head.grp.cnt;
  assign out_valid = head.valid;
  assign out_data.token_kind = t.kind;
  assign out_data.token_column = t.col;
  assign out_data.token_length = t.len;
  assign out_data.last_of_run = last;
  assign pop = head.valid && !out_stall && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (head.valid && !out_stall) begin
      idx_r <= last ? '0 : idx_r + 1'b1;
    end
  end

endmodule

[hw/rtl/c_like_lexer.sv]
// c_like_lexer: top level of the streaming C-like tokenizer.
// Depends on cll_pkg, cll_front, cll_queue and cll_back.
`timescale 1ns / 1ps
// One source byte is taken per input beat and the block keeps up with one
// byte per cycle: the scanner in front works out, in the cycle it accepts a
// byte, every token that byte finishes (zero to four) and parks them as one
// group in a two-deep queue. The output side hands out one token per beat,
// so a byte that ends several tokens occupies the output for one beat per
// token; input is stalled only when both queue slots hold groups not yet
// drained. Byte 10 ends a line; end_of_input flushes any pending token and
// adds an end token (kind 61, length 0). last_of_run marks the final token
// of each byte's group. Bytes that finish no token produce no output beat.
module c_like_lexer import cll_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic acc;
  logic push;
  grp_t push_grp;
  logic pop;
  logic full;
  qrd_t head;

  // input stalls only on a full queue
  assign in_stall = full;
  assign acc = in_valid && !full;

  cll_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .in_data  (in_data),
    .push     (push),
    .push_grp (push_grp)
  );

  cll_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .full     (full),
    .head     (head)
  );

  cll_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
